// ===== hw/rtl/packet_fifo_with_serial_tags_assert.svh =====
// Assertion macros used by the packet FIFO control module.
`ifndef PACKET_FIFO_WITH_SERIAL_TAGS_ASSERT_SVH
`define PACKET_FIFO_WITH_SERIAL_TAGS_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PFST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PFST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfst_pkg.sv =====
// Shared types and constants of the packet FIFO with serial tags.
package pfst_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_SERIAL_BITS = 16;
  localparam logic [7:0] OVERHEAD_RESET = 8'd96;
  localparam int DESC_W = 96;

  typedef enum logic [2:0] {
    OP_PUT       = 3'd0,
    OP_PUT_FLUSH = 3'd1,
    OP_GET       = 3'd2,
    OP_START     = 3'd3,
    OP_ABORT     = 3'd4,
    OP_FLUSH     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABORTED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    status_t      status;
    logic [31:0]  handle;
    logic [7:0]   stream_id;
    logic [23:0]  bytes;
    logic [31:0]  duration;
    logic [15:0]  serial;
    logic         is_flush;
    logic [6:0]   count;
    logic [31:0]  total_bytes;
    logic [47:0]  total_duration;
    logic [15:0]  current_serial;
  } result_t;

endpackage

// ===== hw/rtl/pfst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/pfst_ctrl.sv =====
// Queue control: pointers, totals, serial, abort flag and the request sequencer.
`include "packet_fifo_with_serial_tags_assert.svh"

module pfst_ctrl #(
  parameter int QUEUE_DEPTH = pfst_pkg::DEF_QUEUE_DEPTH,
  parameter int SERIAL_BITS = pfst_pkg::DEF_SERIAL_BITS,
  parameter int PTR_W       = $clog2(QUEUE_DEPTH),
  parameter int ENTRY_W     = pfst_pkg::DESC_W + SERIAL_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             operation,
  input  logic [31:0]            pkt_handle,
  input  logic [7:0]             stream_id,
  input  logic [23:0]            pkt_bytes,
  input  logic [31:0]            pkt_duration,
  output logic                   ram_wr_en,
  output logic [PTR_W-1:0]       ram_wr_addr,
  output logic [ENTRY_W-1:0]     ram_wr_data,
  output logic                   ram_rd_en,
  output logic [PTR_W-1:0]       ram_rd_addr,
  input  logic [ENTRY_W-1:0]     ram_rd_data,
  output logic                   res_valid,
  input  logic                   res_ready,
  output pfst_pkg::result_t      res
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SB = SERIAL_BITS;

  pfst_pkg::state_t  state, state_next;
  pfst_pkg::op_t     op;
  pfst_pkg::status_t st;

  logic [PTR_W-1:0]       head_ptr, head_next, tail_ptr, tail_next;
  logic [PTR_W-1:0]       head_inc, tail_inc;
  logic [CNT_W-1:0]       entry_count, count_next;
  logic [31:0]            byte_sum, byte_sum_next;
  logic [47:0]            duration_sum, duration_sum_next;
  logic [SERIAL_BITS-1:0] generation, generation_next;
  logic                   aborted, aborted_next;
  logic [7:0]             entry_overhead;
  logic                   acc, full, empty;
  logic                   enq_try, chk_abort, mark;
  logic [31:0]            enq_handle, enq_duration;
  logic [7:0]             enq_stream;
  logic [23:0]            enq_bytes;
  logic [31:0]            rd_handle, rd_duration;
  logic [7:0]             rd_stream;
  logic [23:0]            rd_bytes;
  logic [SERIAL_BITS-1:0] rd_serial;
  logic                   rd_flush;

  assign op        = pfst_pkg::op_t'(operation);
  assign in_ready  = (state == pfst_pkg::S_IDLE) && res_ready;
  assign acc       = in_valid && in_ready;
  assign full      = entry_count == CNT_W'(QUEUE_DEPTH);
  assign empty     = entry_count == '0;
  assign head_inc  = (head_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + PTR_W'(1);
  assign tail_inc  = (tail_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr + PTR_W'(1);

  assign rd_flush    = ram_rd_data[0];
  assign rd_serial   = ram_rd_data[SB -: SB];
  assign rd_duration = ram_rd_data[SB + 32 -: 32];
  assign rd_bytes    = ram_rd_data[SB + 56 -: 24];
  assign rd_stream   = ram_rd_data[SB + 64 -: 8];
  assign rd_handle   = ram_rd_data[SB + 96 -: 32];

  assign ram_wr_addr = tail_ptr;
  assign ram_rd_addr = head_ptr;

  always_comb begin
    state_next = state;
    case (state)
      pfst_pkg::S_IDLE: begin
        if (acc && (op == pfst_pkg::OP_GET) && !aborted && !empty) begin
          state_next = pfst_pkg::S_READ;
        end
      end
      pfst_pkg::S_READ: begin
        state_next = pfst_pkg::S_IDLE;
      end
      default: begin
        state_next = pfst_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    head_next         = head_ptr;
    tail_next         = tail_ptr;
    count_next        = entry_count;
    byte_sum_next     = byte_sum;
    duration_sum_next = duration_sum;
    generation_next   = generation;
    aborted_next      = aborted;
    ram_wr_en         = 1'b0;
    ram_rd_en         = 1'b0;
    res_valid         = 1'b0;
    st                = pfst_pkg::ST_OK;
    enq_try           = 1'b0;
    chk_abort         = 1'b1;
    mark              = 1'b0;
    res               = '0;
    case (state)
      pfst_pkg::S_IDLE: begin
        if (acc) begin
          res_valid = 1'b1;
          case (op)
            pfst_pkg::OP_PUT: begin
              enq_try = 1'b1;
            end
            pfst_pkg::OP_PUT_FLUSH: begin
              enq_try = 1'b1;
              mark    = 1'b1;
            end
            pfst_pkg::OP_GET: begin
              if (aborted) begin
                st = pfst_pkg::ST_ABORTED;
              end else if (empty) begin
                st = pfst_pkg::ST_EMPTY;
              end else begin
                ram_rd_en = 1'b1;
                res_valid = 1'b0;
              end
            end
            pfst_pkg::OP_START: begin
              aborted_next = 1'b0;
              enq_try      = 1'b1;
              chk_abort    = 1'b0;
              mark         = 1'b1;
            end
            pfst_pkg::OP_ABORT: begin
              aborted_next = 1'b1;
            end
            pfst_pkg::OP_FLUSH: begin
              head_next         = '0;
              tail_next         = '0;
              count_next        = '0;
              byte_sum_next     = '0;
              duration_sum_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      pfst_pkg::S_READ: begin
        res_valid         = 1'b1;
        head_next         = head_inc;
        count_next        = entry_count - CNT_W'(1);
        byte_sum_next     = byte_sum - 32'(rd_bytes) - 32'(entry_overhead);
        duration_sum_next = duration_sum - 48'(rd_duration);
        res.handle        = rd_handle;
        res.stream_id     = rd_stream;
        res.bytes         = rd_bytes;
        res.duration      = rd_duration;
        res.serial        = 16'(rd_serial);
        res.is_flush      = rd_flush;
      end
      default: begin
      end
    endcase

    enq_handle   = mark ? '0 : pkt_handle;
    enq_stream   = mark ? '0 : stream_id;
    enq_bytes    = mark ? '0 : pkt_bytes;
    enq_duration = mark ? '0 : pkt_duration;

    if (enq_try) begin
      if (chk_abort && aborted) begin
        st = pfst_pkg::ST_ABORTED;
      end else if (full) begin
        st = pfst_pkg::ST_FULL;
      end else begin
        ram_wr_en         = 1'b1;
        tail_next         = tail_inc;
        count_next        = entry_count + CNT_W'(1);
        generation_next   = mark ? generation + SERIAL_BITS'(1) : generation;
        byte_sum_next     = byte_sum + 32'(enq_bytes) + 32'(entry_overhead);
        duration_sum_next = duration_sum + 48'(enq_duration);
      end
    end

    ram_wr_data = {enq_handle, enq_stream, enq_bytes, enq_duration, generation_next, mark};

    res.status         = st;
    res.count          = 7'(count_next);
    res.total_bytes    = byte_sum_next;
    res.total_duration = duration_sum_next;
    res.current_serial = 16'(generation_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pfst_pkg::S_IDLE;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      entry_count  <= '0;
      byte_sum     <= '0;
      duration_sum <= '0;
      generation   <= '0;
      aborted      <= 1'b1;
    end else begin
      state        <= state_next;
      head_ptr     <= head_next;
      tail_ptr     <= tail_next;
      entry_count  <= count_next;
      byte_sum     <= byte_sum_next;
      duration_sum <= duration_sum_next;
      generation   <= generation_next;
      aborted      <= aborted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_overhead <= pfst_pkg::OVERHEAD_RESET;
    end else if (cfg_wr_en) begin
      entry_overhead <= cfg_wr_data;
    end
  end

  `PFST_ASSERT_IMPL(a_count_bound, 1'b1, entry_count <= CNT_W'(QUEUE_DEPTH), "Count above depth.")
  `PFST_ASSERT_NEXT(a_read_once, state == pfst_pkg::S_READ, state == pfst_pkg::S_IDLE, "Long read.")
  `PFST_ASSERT_IMPL(a_result_has_room, res_valid, res_ready, "Result while output full.")
  `PFST_ASSERT_NEXT(a_read_follows_fetch, ram_rd_en, res_valid, "Fetch gave no result.")

endmodule

// ===== hw/rtl/pfst_out.sv =====
// Output register stage that holds one result until the consumer takes it.
module pfst_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  pfst_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output pfst_pkg::result_t out_res
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ===== hw/rtl/packet_fifo_with_serial_tags.sv =====
// Top level of the packet descriptor FIFO with generation serial tags.
// A result is registered in the output stage and appears in the cycle after its request is
// taken; a get that returns an entry passes first through the registered slot memory read and
// then through the output register. Throughput: one request per cycle while results are taken;
// a successful get holds off the next request while the slot is read. Reset clears pointers,
// totals and serial, sets the abort flag and loads an overhead of 96; the slot memory is not cleared.
module packet_fifo_with_serial_tags #(
  parameter int QUEUE_DEPTH = pfst_pkg::DEF_QUEUE_DEPTH,
  parameter int SERIAL_BITS = pfst_pkg::DEF_SERIAL_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] pkt_handle,
  input  logic [7:0]  stream_id,
  input  logic [23:0] pkt_bytes,
  input  logic [31:0] pkt_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] out_handle,
  output logic [7:0]  out_stream_id,
  output logic [23:0] out_bytes,
  output logic [31:0] out_duration,
  output logic [15:0] out_serial,
  output logic        out_is_flush,
  output logic [6:0]  count,
  output logic [31:0] total_bytes,
  output logic [47:0] total_duration,
  output logic [15:0] current_serial
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int ENTRY_W = pfst_pkg::DESC_W + SERIAL_BITS + 1;

  logic               ram_wr_en, ram_rd_en;
  logic [PTR_W-1:0]   ram_wr_addr, ram_rd_addr;
  logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
  logic               res_valid, res_ready;
  pfst_pkg::result_t  res, out_res;

  pfst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  pfst_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SERIAL_BITS (SERIAL_BITS),
    .PTR_W       (PTR_W),
    .ENTRY_W     (ENTRY_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .pkt_handle   (pkt_handle),
    .stream_id    (stream_id),
    .pkt_bytes    (pkt_bytes),
    .pkt_duration (pkt_duration),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  pfst_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign status         = out_res.status;
  assign out_handle     = out_res.handle;
  assign out_stream_id  = out_res.stream_id;
  assign out_bytes      = out_res.bytes;
  assign out_duration   = out_res.duration;
  assign out_serial     = out_res.serial;
  assign out_is_flush   = out_res.is_flush;
  assign count          = out_res.count;
  assign total_bytes    = out_res.total_bytes;
  assign total_duration = out_res.total_duration;
  assign current_serial = out_res.current_serial;

endmodule
